>>> hw/rtl/kmpsm_pkg.sv
package kmpsm_pkg;

   // payload widths
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int PAT_LEN_W  = 5;

   // bytes held by each pattern register and by both together
   localparam int BYTES_PER_WORD = CSR_DATA_W / BYTE_W;
   localparam int PAT_REG_BYTES  = 2 * BYTES_PER_WORD;

   // default pattern capacity
   localparam int MAX_PATTERN_BYTES_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PAT_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN  = CSR_IDX_W'(2);

   // pattern byte at a position, zero past the pattern registers
   function automatic logic [BYTE_W-1:0] pattern_byte(
      input logic [CSR_DATA_W-1:0] lo,
      input logic [CSR_DATA_W-1:0] hi,
      input int                    idx
   );
      logic [BYTE_W-1:0] b;
      b = '0;
      if (idx < BYTES_PER_WORD) begin
         b = lo[BYTE_W*idx +: BYTE_W];
      end else if (idx < PAT_REG_BYTES) begin
         b = hi[BYTE_W*(idx-BYTES_PER_WORD) +: BYTE_W];
      end
      return b;
   endfunction

endpackage

>>> hw/rtl/kmpsm_if.sv
// text byte channel
interface kmpsm_req_if;
   import kmpsm_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              last_byte;
   logic              empty_text;

   modport source (output valid, text_byte, last_byte, empty_text, input ready);
   modport sink   (input valid, text_byte, last_byte, empty_text, output ready);
endinterface

// match result channel
interface kmpsm_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic text_done;

   modport source (output valid, found, text_done, input ready);
   modport sink   (input valid, found, text_done, output ready);
endinterface

// register write channel
interface kmpsm_csr_if;
   import kmpsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kmp_substring_match.sv
// Streaming substring search. Each text byte enters a row of one cell per pattern
// byte; cell k holds whether the last k+1 text bytes equal the first k+1 pattern
// bytes and passes that bit to cell k+1, so a text byte is taken every cycle while
// scanning with the result register free or being read; its result (sticky found
// flag, end-of-text mark) is in the output register the next cycle. found and
// the cell row clear after each text's last item or an empty-text item. An empty
// pattern reports found on every result. A write to a known register index starts
// a realignment of the row: a setup state, then a replay of the kept partial match
// (at most MAX_PATTERN_BYTES-1 bytes); no byte or register write is then taken.
module kmp_substring_match #(
   parameter int MAX_PATTERN_BYTES = kmpsm_pkg::MAX_PATTERN_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   kmpsm_req_if.sink   req_bus,
   kmpsm_rsp_if.source rsp_bus,
   kmpsm_csr_if.sink   csr_bus
);
   import kmpsm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   typedef enum logic [2:0] {
      ST_SCAN   = 3'b001,
      ST_PREP   = 3'b010,
      ST_REPLAY = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in;
   logic [CSR_DATA_W-1:0] pat_hi_ff, pat_hi_in;
   logic [PAT_LEN_W-1:0]  pat_len_ff, pat_len_in;
   logic                  found_ff, found_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [LEN_W-1:0]      replay_len_ff, replay_len_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [LEN_W-1:0]             act_len;
   logic [BYTE_W-1:0]            cell_byte [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] active;
   logic [MAX_PATTERN_BYTES-1:0] hit;
   logic [MAX_PATTERN_BYTES-1:0] keep;
   logic [MAX_PATTERN_BYTES-1:0] last_sel;
   logic [MAX_PATTERN_BYTES-1:0] prev_active;
   logic [BYTE_W-1:0]            feed_byte;
   logic                         step;
   logic                         clear;
   logic                         req_beat;
   logic                         csr_beat;
   logic                         csr_hit;
   logic                         full_match;
   logic                         found_now;
   logic                         text_end;
   logic [LEN_W-1:0]             live_len;
   logic [LEN_W-1:0]             kept_len;

   // pattern length in use, capped at the row length
   always_comb begin
      if (int'(pat_len_ff) > MAX_PATTERN_BYTES) begin
         act_len = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         act_len = LEN_W'(pat_len_ff);
      end
   end

   // per-cell pattern byte, live mask and match tap
   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      assign cell_byte[k] = pattern_byte(pat_lo_ff, pat_hi_ff, k);
      assign keep[k]      = (k + 1) < int'(act_len);
      assign last_sel[k]  = (k + 1) == int'(act_len);
      if (k == 0) begin : g_head
         assign prev_active[k] = 1'b1;
      end else begin : g_body
         assign prev_active[k] = active[k-1];
      end

      kmpsm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .prev_active (prev_active[k]),
         .pat_byte    (cell_byte[k]),
         .feed_byte   (feed_byte),
         .step        (step),
         .clear       (clear),
         .keep        (keep[k]),
         .active      (active[k]),
         .hit         (hit[k])
      );
   end

   // handshakes
   assign req_bus.ready = (state_ff == ST_SCAN) && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = (state_ff == ST_SCAN);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_beat      = csr_bus.valid && csr_bus.ready;
   assign csr_hit       = csr_beat && (csr_bus.index == REG_PAT_LOW ||
                                       csr_bus.index == REG_PAT_HIGH ||
                                       csr_bus.index == REG_PAT_LEN);

   // byte into the row: text while scanning, pattern prefix while realigning
   always_comb begin
      feed_byte = req_bus.text_byte;
      if (state_ff == ST_REPLAY) begin
         feed_byte = cell_byte[count_ff[IDX_W-1:0]];
      end
   end

   assign step = (state_ff == ST_REPLAY) || (req_beat && !req_bus.empty_text);
   assign text_end = req_beat && (req_bus.empty_text || req_bus.last_byte);
   assign clear = text_end || (state_ff == ST_PREP);

   assign full_match = (act_len != '0) && (|(hit & last_sel)) && !req_bus.empty_text;
   assign found_now  = (act_len == '0) || found_ff || full_match;

   // longest live partial match, dropped when it no longer fits the pattern
   always_comb begin
      live_len = '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         if (active[k]) begin
            live_len = LEN_W'(k + 1);
         end
      end
      kept_len = (live_len >= act_len) ? '0 : live_len;
   end

   // registers, control sequencing and result register
   always_comb begin
      state_in      = state_ff;
      pat_lo_in     = pat_lo_ff;
      pat_hi_in     = pat_hi_ff;
      pat_len_in    = pat_len_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      replay_len_in = replay_len_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_done_in   = rsp_done_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SCAN: begin
            if (csr_hit) begin
               unique case (csr_bus.index)
                  REG_PAT_LOW:  pat_lo_in  = csr_bus.data;
                  REG_PAT_HIGH: pat_hi_in  = csr_bus.data;
                  default:      pat_len_in = csr_bus.data[PAT_LEN_W-1:0];
               endcase
               state_in = ST_PREP;
            end
            if (req_beat) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_now;
               rsp_done_in  = text_end;
               if (text_end) begin
                  found_in = 1'b0;
               end else if (full_match) begin
                  found_in = 1'b1;
               end
            end
         end
         ST_PREP: begin
            count_in      = '0;
            replay_len_in = kept_len;
            state_in      = (kept_len == '0) ? ST_SCAN : ST_REPLAY;
         end
         ST_REPLAY: begin
            count_in = count_ff + LEN_W'(1);
            if (count_in == replay_len_ff) begin
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         pat_len_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         pat_len_ff   <= pat_len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      replay_len_ff <= replay_len_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.text_done = rsp_done_ff;

endmodule

>>> hw/rtl/kmpsm_cell.sv
module kmpsm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        prev_active,
   input  logic [kmpsm_pkg::BYTE_W-1:0] pat_byte,
   input  logic [kmpsm_pkg::BYTE_W-1:0] feed_byte,
   input  logic                        step,
   input  logic                        clear,
   input  logic                        keep,
   output logic                        active,
   output logic                        hit
);
   import kmpsm_pkg::*;

   logic active_ff;
   logic active_in;

   // prefix extends by one byte when the neighbor's prefix was live and the bytes match
   assign hit = prev_active && (pat_byte == feed_byte);

   always_comb begin
      active_in = active_ff;
      if (clear) begin
         active_in = 1'b0;
      end else if (step) begin
         active_in = hit && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule
